[sv/bmp_header_validator_assert.svh]
// assertion macros for the bmp header validator
// no dependencies; included by the top level only
`ifndef BMP_HEADER_VALIDATOR_ASSERT_SVH
`define BMP_HEADER_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
// check with the property disabled while reset is high
`define BMPV_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmp header validator: assertion failed");
// check that also holds through reset
`define BMPV_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bmp header validator: assertion failed");
`else
`define BMPV_ASSERT(label, clk, rst, prop)
`define BMPV_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[sv/bmpv_pkg.sv]
// shared types, constants and helpers for the bmp header validator
// no dependencies; used by every module of the block
package bmpv_pkg;

   // header layout and limits
   localparam int unsigned HDR_BYTES    = 54;
   localparam int unsigned MIN_FILE     = 62;
   localparam int unsigned MAX_WIDTH    = 2048;
   localparam int unsigned MAX_HEIGHT   = 3072;
   localparam int unsigned MAX_PALETTE  = 256;
   localparam int unsigned DIB_MIN      = 40;
   localparam int unsigned ENTRY_BYTES  = 4;
   localparam int unsigned STRIDE_ROUND = 31;
   localparam int unsigned SLOTS        = 30;
   localparam logic [15:0] SIG_BM       = 16'h4D42;
   localparam logic [15:0] COMP_NONE    = 16'd0;
   localparam logic [15:0] COMP_MASKS   = 16'd3;

   // header offsets that are kept
   localparam logic [10:0] OFF_SIG_HI   = 11'd1;
   localparam logic [10:0] OFF_MAIN_LO  = 11'd10;
   localparam logic [10:0] OFF_MAIN_HI  = 11'd33;
   localparam logic [10:0] OFF_CU_LO    = 11'd46;
   localparam logic [10:0] OFF_CU_HI    = 11'd49;
   localparam logic [10:0] MAIN_SHIFT   = 11'd8;
   localparam logic [10:0] CU_SHIFT     = 11'd20;

   // luminance weights
   localparam logic [15:0] LUM_RED      = 16'd77;
   localparam logic [15:0] LUM_GREEN    = 16'd150;
   localparam logic [15:0] LUM_BLUE     = 16'd29;

   // register port
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   typedef enum logic [0:0] {
      REG_FILE_LENGTH = 1'b0
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_INVALID     = 4'd1,
      ST_NOT_BMP     = 4'd2,
      ST_DIB_SMALL   = 4'd3,
      ST_PLANES      = 4'd4,
      ST_BPP         = 4'd5,
      ST_COMPRESSION = 4'd6,
      ST_PALETTE_BIG = 4'd7,
      ST_DIMS        = 4'd8,
      ST_TOO_LARGE   = 4'd9
   } status_type;

   typedef enum logic {
      KIND_HEADER  = 1'b0,
      KIND_PALETTE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_HDR,
      S_STRIDE,
      S_FIT,
      S_PFIT,
      S_LUM_R,
      S_LUM_G,
      S_LUM_B,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        hit;
      logic [4:0]  slot;
   } slot_type;

   typedef struct packed {
      logic [15:0] sig;
      logic [31:0] offs;
      logic [31:0] dib;
      logic [31:0] rw;
      logic [31:0] rh;
      logic [15:0] planes;
      logic [15:0] bp;
      logic [31:0] comp;
      logic [31:0] cu;
   } hdr_fields_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } entry_type;

   // events raised by the capture stage on an accepted byte
   typedef struct packed {
      logic       hdr_end;
      logic       pal_end;
      logic       pal_last;
      logic [7:0] pal_index;
   } cap_evt_type;

   // header outcome handed back to the capture stage
   typedef struct packed {
      logic       load;
      logic [8:0] count;
   } hdr_set_type;

   typedef struct packed {
      logic        en;
      logic [15:0] a;
      logic [15:0] b;
      logic [32:0] c;
   } mac_op_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [11:0] width;
      logic [11:0] height;
      logic [5:0]  bpp;
      logic        top_down;
      logic [13:0] stride;
      logic [31:0] offset;
      logic [8:0]  pal_count;
      logic [7:0]  pal_index;
      logic [7:0]  luminance;
      logic        last;
   } rsp_type;

   // store slot of a header byte offset
   function automatic slot_type slot_of(input logic [10:0] off);
      slot_type s;
      s.hit  = 1'b0;
      s.slot = '0;
      if (off <= OFF_SIG_HI) begin
         s.hit  = 1'b1;
         s.slot = off[4:0];
      end else if (off >= OFF_MAIN_LO && off <= OFF_MAIN_HI) begin
         s.hit  = 1'b1;
         s.slot = 5'(off - MAIN_SHIFT);
      end else if (off >= OFF_CU_LO && off <= OFF_CU_HI) begin
         s.hit  = 1'b1;
         s.slot = 5'(off - CU_SHIFT);
      end
      return s;
   endfunction

endpackage

[sv/bmpv_mac.sv]
// shared multiply-accumulate unit: result = a * b + c, registered
// depends on bmpv_pkg
module bmpv_mac (
   input  logic                clock,
   input  bmpv_pkg::mac_op_type op,
   output logic [33:0]         result
);

   logic [31:0] product;
   logic [33:0] result_in;
   logic [33:0] result_ff;

   // one multiply and one add per cycle
   always_comb begin
      product   = op.a * op.b;
      result_in = 34'(product) + 34'(op.c);
   end

   // result holds while no operation is issued
   always_ff @(posedge clock) begin
      if (op.en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[sv/bmpv_capture.sv]
// byte counter, header byte store and palette entry capture
// depends on bmpv_pkg
module bmpv_capture (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  logic [7:0]               byte_value,
   input  logic                     start_of_file,
   input  bmpv_pkg::hdr_set_type    hdr_set,
   output bmpv_pkg::cap_evt_type    evt,
   output bmpv_pkg::hdr_fields_type fields,
   output bmpv_pkg::entry_type      entry
);

   logic [10:0] byte_count_ff, byte_count_in;
   logic        parse_done_ff, parse_done_in;
   logic [8:0]  entries_left_ff, entries_left_in;
   logic [7:0]  hdr_ff [bmpv_pkg::SLOTS];
   logic [7:0]  blue_ff, green_ff, red_ff;

   logic [10:0]        offset;
   logic [10:0]        rel;
   logic               active;
   logic               in_header;
   logic               last;
   bmpv_pkg::slot_type slot;

   // byte position and counter update
   always_comb begin
      offset          = start_of_file ? '0 : byte_count_ff;
      active          = byte_accept && (start_of_file || !parse_done_ff);
      in_header       = offset < 11'(bmpv_pkg::HDR_BYTES);
      rel             = offset - 11'(bmpv_pkg::HDR_BYTES);
      slot            = bmpv_pkg::slot_of(offset);
      last            = entries_left_ff <= 9'd1;
      byte_count_in   = byte_count_ff;
      parse_done_in   = parse_done_ff;
      entries_left_in = entries_left_ff;
      evt             = '0;
      if (byte_accept && start_of_file) begin
         parse_done_in   = 1'b0;
         entries_left_in = '0;
      end
      if (active) begin
         byte_count_in = offset + 11'd1;
         if (in_header) begin
            evt.hdr_end = offset == 11'(bmpv_pkg::HDR_BYTES - 1);
         end else if (rel[1:0] == 2'd3) begin
            evt.pal_end     = 1'b1;
            evt.pal_last    = last;
            evt.pal_index   = rel[9:2];
            entries_left_in = entries_left_ff - 9'(entries_left_ff != '0);
            if (last) begin
               parse_done_in = 1'b1;
            end
         end
      end
      // header outcome from the sequencer
      if (hdr_set.load) begin
         entries_left_in = hdr_set.count;
         parse_done_in   = hdr_set.count == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         parse_done_ff   <= 1'b1;
         entries_left_ff <= '0;
      end else begin
         byte_count_ff   <= byte_count_in;
         parse_done_ff   <= parse_done_in;
         entries_left_ff <= entries_left_in;
      end
   end

   // header bytes and palette entry bytes
   always_ff @(posedge clock) begin
      if (active && in_header && slot.hit) begin
         hdr_ff[slot.slot] <= byte_value;
      end
      if (active && !in_header) begin
         case (rel[1:0])
            2'd0: begin
               blue_ff <= byte_value;
            end
            2'd1: begin
               green_ff <= byte_value;
            end
            2'd2: begin
               red_ff <= byte_value;
            end
            default: begin
            end
         endcase
      end
   end

   // little-endian field view of the store
   always_comb begin
      fields.sig    = {hdr_ff[1], hdr_ff[0]};
      fields.offs   = {hdr_ff[5], hdr_ff[4], hdr_ff[3], hdr_ff[2]};
      fields.dib    = {hdr_ff[9], hdr_ff[8], hdr_ff[7], hdr_ff[6]};
      fields.rw     = {hdr_ff[13], hdr_ff[12], hdr_ff[11], hdr_ff[10]};
      fields.rh     = {hdr_ff[17], hdr_ff[16], hdr_ff[15], hdr_ff[14]};
      fields.planes = {hdr_ff[19], hdr_ff[18]};
      fields.bp     = {hdr_ff[21], hdr_ff[20]};
      fields.comp   = {hdr_ff[25], hdr_ff[24], hdr_ff[23], hdr_ff[22]};
      fields.cu     = {hdr_ff[29], hdr_ff[28], hdr_ff[27], hdr_ff[26]};
      entry.blue    = blue_ff;
      entry.green   = green_ff;
      entry.red     = red_ff;
   end

endmodule

[sv/bmpv_seq.sv]
// sequencer: header checks, fit sums and luminance on the shared mac, result register
// depends on bmpv_pkg
module bmpv_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_accept,
   input  bmpv_pkg::cap_evt_type    evt,
   input  bmpv_pkg::hdr_fields_type fields,
   input  bmpv_pkg::entry_type      entry,
   input  logic [23:0]              file_length,
   input  logic [33:0]              mac_result,
   input  logic                     rsp_ready,
   output logic                     req_ready,
   output bmpv_pkg::mac_op_type     mac_op,
   output bmpv_pkg::hdr_set_type    hdr_set,
   output logic                     rsp_valid,
   output bmpv_pkg::rsp_type        rsp
);

   bmpv_pkg::state_type  state_ff, state_in;
   bmpv_pkg::status_type status_ff, status_in;
   bmpv_pkg::status_type early_status;
   bmpv_pkg::kind_type   kind_ff, kind_in;
   logic                 fit_fail_ff, fit_fail_in;
   logic [11:0]          mag_ff, mag_in;
   logic [13:0]          stride_ff, stride_in;
   logic                 top_down_ff, top_down_in;
   logic [7:0]           pal_index_ff, pal_index_in;
   logic                 pal_last_ff, pal_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bmpv_pkg::rsp_type    rsp_ff, rsp_in;

   logic        neg;
   logic [31:0] mag_full;
   logic        bpp_ok;
   logic        comp_ok;
   logic        hdr_ok;
   logic        pal_fail;

   // header checks in priority order
   always_comb begin
      neg      = fields.rh[31];
      mag_full = neg ? (32'd0 - fields.rh) : fields.rh;
      bpp_ok   = fields.bp == 16'd1 || fields.bp == 16'd2 || fields.bp == 16'd8 ||
                 fields.bp == 16'd24 || fields.bp == 16'd32;
      comp_ok  = fields.comp == 32'(bmpv_pkg::COMP_NONE) ||
                 (fields.bp == 16'd32 && fields.comp == 32'(bmpv_pkg::COMP_MASKS));
      if (file_length < 24'(bmpv_pkg::MIN_FILE)) begin
         early_status = bmpv_pkg::ST_INVALID;
      end else if (fields.sig != bmpv_pkg::SIG_BM) begin
         early_status = bmpv_pkg::ST_NOT_BMP;
      end else if (fields.dib < 32'(bmpv_pkg::DIB_MIN)) begin
         early_status = bmpv_pkg::ST_DIB_SMALL;
      end else if (fields.planes != 16'd1) begin
         early_status = bmpv_pkg::ST_PLANES;
      end else if (!bpp_ok) begin
         early_status = bmpv_pkg::ST_BPP;
      end else if (!comp_ok) begin
         early_status = bmpv_pkg::ST_COMPRESSION;
      end else if (fields.cu > 32'(bmpv_pkg::MAX_PALETTE)) begin
         early_status = bmpv_pkg::ST_PALETTE_BIG;
      end else if (fields.rw[31] || fields.rw == '0 || mag_full == '0 || mag_full[31]) begin
         early_status = bmpv_pkg::ST_DIMS;
      end else if (fields.rw > 32'(bmpv_pkg::MAX_WIDTH) ||
                   mag_full > 32'(bmpv_pkg::MAX_HEIGHT)) begin
         early_status = bmpv_pkg::ST_TOO_LARGE;
      end else begin
         early_status = bmpv_pkg::ST_OK;
      end
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      kind_in      = kind_ff;
      fit_fail_in  = fit_fail_ff;
      mag_in       = mag_ff;
      stride_in    = stride_ff;
      top_down_in  = top_down_ff;
      pal_index_in = pal_index_ff;
      pal_last_in  = pal_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mac_op       = '0;
      hdr_set      = '0;
      hdr_ok       = status_ff == bmpv_pkg::ST_OK;
      pal_fail     = fields.cu != '0 && mac_result > 34'(file_length);
      case (state_ff)
         bmpv_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (byte_accept && evt.hdr_end) begin
               kind_in  = bmpv_pkg::KIND_HEADER;
               state_in = bmpv_pkg::S_HDR;
            end else if (byte_accept && evt.pal_end) begin
               kind_in      = bmpv_pkg::KIND_PALETTE;
               pal_index_in = evt.pal_index;
               pal_last_in  = evt.pal_last;
               state_in     = bmpv_pkg::S_LUM_R;
            end
         end
         bmpv_pkg::S_HDR: begin
            status_in   = early_status;
            mag_in      = mag_full[11:0];
            top_down_in = neg;
            if (early_status != bmpv_pkg::ST_OK) begin
               state_in = bmpv_pkg::S_OUT;
            end else begin
               // width * bpp + 31
               mac_op.en = 1'b1;
               mac_op.a  = 16'(fields.rw[11:0]);
               mac_op.b  = fields.bp;
               mac_op.c  = 33'(bmpv_pkg::STRIDE_ROUND);
               state_in  = bmpv_pkg::S_STRIDE;
            end
         end
         bmpv_pkg::S_STRIDE: begin
            // padded row bytes, then offset + stride * height
            stride_in = {mac_result[16:5], 2'b00};
            mac_op.en = 1'b1;
            mac_op.a  = 16'(stride_in);
            mac_op.b  = 16'(mag_ff);
            mac_op.c  = 33'(fields.offs);
            state_in  = bmpv_pkg::S_FIT;
         end
         bmpv_pkg::S_FIT: begin
            // pixel data fit, then 54 + 4 * colours
            fit_fail_in = mac_result > 34'(file_length);
            mac_op.en   = 1'b1;
            mac_op.a    = fields.cu[15:0];
            mac_op.b    = 16'(bmpv_pkg::ENTRY_BYTES);
            mac_op.c    = 33'(bmpv_pkg::HDR_BYTES);
            state_in    = bmpv_pkg::S_PFIT;
         end
         bmpv_pkg::S_PFIT: begin
            if (fit_fail_ff || pal_fail) begin
               status_in = bmpv_pkg::ST_INVALID;
            end
            state_in = bmpv_pkg::S_OUT;
         end
         bmpv_pkg::S_LUM_R: begin
            mac_op.en = 1'b1;
            mac_op.a  = bmpv_pkg::LUM_RED;
            mac_op.b  = 16'(entry.red);
            mac_op.c  = '0;
            state_in  = bmpv_pkg::S_LUM_G;
         end
         bmpv_pkg::S_LUM_G: begin
            mac_op.en = 1'b1;
            mac_op.a  = bmpv_pkg::LUM_GREEN;
            mac_op.b  = 16'(entry.green);
            mac_op.c  = 33'(mac_result);
            state_in  = bmpv_pkg::S_LUM_B;
         end
         bmpv_pkg::S_LUM_B: begin
            mac_op.en = 1'b1;
            mac_op.a  = bmpv_pkg::LUM_BLUE;
            mac_op.b  = 16'(entry.blue);
            mac_op.c  = 33'(mac_result);
            state_in  = bmpv_pkg::S_OUT;
         end
         bmpv_pkg::S_OUT: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.kind  = kind_ff;
               if (kind_ff == bmpv_pkg::KIND_HEADER) begin
                  rsp_in.status = status_ff;
                  rsp_in.last   = !hdr_ok || fields.cu == '0;
                  hdr_set.load  = 1'b1;
                  if (hdr_ok) begin
                     rsp_in.width     = fields.rw[11:0];
                     rsp_in.height    = mag_ff;
                     rsp_in.bpp       = fields.bp[5:0];
                     rsp_in.top_down  = top_down_ff;
                     rsp_in.stride    = stride_ff;
                     rsp_in.offset    = fields.offs;
                     rsp_in.pal_count = fields.cu[8:0];
                     hdr_set.count    = fields.cu[8:0];
                  end
               end else begin
                  rsp_in.status    = bmpv_pkg::ST_OK;
                  rsp_in.pal_index = pal_index_ff;
                  rsp_in.luminance = mac_result[15:8];
                  rsp_in.last      = pal_last_ff;
               end
               state_in = bmpv_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmpv_pkg::S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmpv_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working values and result payload
   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      kind_ff      <= kind_in;
      fit_fail_ff  <= fit_fail_in;
      mag_ff       <= mag_in;
      stride_ff    <= stride_in;
      top_down_ff  <= top_down_in;
      pal_index_ff <= pal_index_in;
      pal_last_ff  <= pal_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[sv/bmp_header_validator.sv]
// top level of the bmp header validator: register port, capture, sequencer, shared mac
// depends on bmpv_pkg, bmpv_capture, bmpv_seq, bmpv_mac and bmp_header_validator_assert.svh
//
//   channel   direction  handshake               content
//   req_      in         req_valid / req_ready   one file byte and start flag
//   rsp_      out        rsp_valid / rsp_ready   header summary or palette luminance
//   apb       in         psel, penable, pready   file_length at byte address 0
//
// a byte is taken while the sequencer is idle; the 54th header byte runs the checks,
// stride, pixel fit and palette fit (only the checks when one fails), the 4th palette
// entry byte red, green and blue, all on the single multiply-accumulate unit.
// the result register lets header and pixel bytes keep flowing while a result waits;
// a result-bearing byte holds in its last state until rsp_ready frees the register.
// synchronous reset clears the control state and file_length; the block then
// ignores bytes until one arrives with start_of_file.
`include "bmp_header_validator_assert.svh"
module bmp_header_validator (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_byte_value,
   input  logic                              req_start_of_file,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_result_kind,
   output logic [3:0]                        rsp_status,
   output logic [11:0]                       rsp_image_width,
   output logic [11:0]                       rsp_image_height,
   output logic [5:0]                        rsp_bits_per_pixel,
   output logic                              rsp_top_down,
   output logic [13:0]                       rsp_row_stride,
   output logic [31:0]                       rsp_data_offset,
   output logic [8:0]                        rsp_palette_count,
   output logic [7:0]                        rsp_palette_index,
   output logic [7:0]                        rsp_luminance,
   output logic                              rsp_last,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bmpv_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bmpv_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bmpv_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic [23:0]               file_length_ff, file_length_in;
   logic                      csr_write;
   bmpv_pkg::reg_index_type   reg_index;
   logic                      byte_accept;
   bmpv_pkg::cap_evt_type     evt;
   bmpv_pkg::hdr_fields_type  fields;
   bmpv_pkg::entry_type       entry;
   bmpv_pkg::hdr_set_type     hdr_set;
   bmpv_pkg::mac_op_type      mac_op;
   logic [33:0]               mac_result;
   bmpv_pkg::rsp_type         rsp;
   logic                      rsp_is_pal;
   logic                      rsp_is_fail;

   // register port decode
   always_comb begin
      pready         = 1'b1;
      csr_write      = psel && penable && pwrite && pready;
      reg_index      = bmpv_pkg::reg_index_type'(paddr[2]);
      file_length_in = file_length_ff;
      prdata         = '0;
      case (reg_index)
         bmpv_pkg::REG_FILE_LENGTH: begin
            prdata = bmpv_pkg::CSR_DATA_W'(file_length_ff);
            if (csr_write) begin
               file_length_in = pwdata[23:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else begin
         file_length_ff <= file_length_in;
      end
   end

   assign byte_accept = req_valid && req_ready;

   bmpv_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .byte_accept   (byte_accept),
      .byte_value    (req_byte_value),
      .start_of_file (req_start_of_file),
      .hdr_set       (hdr_set),
      .evt           (evt),
      .fields        (fields),
      .entry         (entry)
   );

   bmpv_mac u_mac (
      .clock  (clock),
      .op     (mac_op),
      .result (mac_result)
   );

   bmpv_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .evt         (evt),
      .fields      (fields),
      .entry       (entry),
      .file_length (file_length_ff),
      .mac_result  (mac_result),
      .rsp_ready   (rsp_ready),
      .req_ready   (req_ready),
      .mac_op      (mac_op),
      .hdr_set     (hdr_set),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   // result fields onto the ports
   always_comb begin
      rsp_result_kind    = rsp.kind;
      rsp_status         = rsp.status;
      rsp_image_width    = rsp.width;
      rsp_image_height   = rsp.height;
      rsp_bits_per_pixel = rsp.bpp;
      rsp_top_down       = rsp.top_down;
      rsp_row_stride     = rsp.stride;
      rsp_data_offset    = rsp.offset;
      rsp_palette_count  = rsp.pal_count;
      rsp_palette_index  = rsp.pal_index;
      rsp_luminance      = rsp.luminance;
      rsp_last           = rsp.last;
   end

   // result classes for the checks below
   always_comb begin
      rsp_is_pal  = rsp_valid && rsp_result_kind == bmpv_pkg::KIND_PALETTE;
      rsp_is_fail = rsp_valid && rsp_result_kind == bmpv_pkg::KIND_HEADER &&
                    rsp_status != bmpv_pkg::ST_OK;
   end

   // the sequencer stops taking bytes once the header is complete
   `BMPV_ASSERT(a_hdr_end_stalls, clock, reset, byte_accept && evt.hdr_end |=> !req_ready)
   // a new result is only loaded from a busy sequencer
   `BMPV_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> !$past(req_ready))
   // palette results carry ok status, failed headers end the file with no geometry
   `BMPV_ASSERT(a_pal_status, clock, reset, rsp_is_pal |-> rsp_status == bmpv_pkg::ST_OK)
   `BMPV_ASSERT(a_fail_last, clock, reset, rsp_is_fail |-> rsp_last && rsp_image_width == '0)
   // no result survives reset
   `BMPV_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

endmodule
